// ===== hdl/seconds_to_calendar_date_core_macros.svh =====
`ifndef SECONDS_TO_CALENDAR_DATE_CORE_MACROS_SVH
`define SECONDS_TO_CALENDAR_DATE_CORE_MACROS_SVH

// Check that cond holds in the same cycle as trig, outside reset.
`define STCD_ASSERT_IMPL(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check that cond holds in the cycle after trig, outside reset.
`define STCD_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== hdl/stcd_pkg.sv =====
`timescale 1ns / 1ps

package stcd_pkg;

	// Pipeline depth, request in to result out.
	localparam int NUM_STAGES = 10;

	typedef logic [NUM_STAGES:1] stage_adv_t;

	typedef logic [15:0] uday_t;     // whole days since 1 Jan 1970
	typedef logic [16:0] daysec_t;   // seconds within the day

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} clock_t;

	typedef struct packed {
		logic [4:0]  day_of_month;
		logic [3:0]  month;
		logic [11:0] year;
		logic [2:0]  week_day;
		logic [8:0]  year_day;
	} date_t;

	localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;

	localparam int SECS_MIN  = 60;
	localparam int SECS_DAY  = 86400;
	localparam int DAY_SHIFT = 7;                       // 86400 = 675 << 7
	localparam int DAY_ODD   = SECS_DAY >> DAY_SHIFT;

	localparam int DAYS_YEAR = 365;
	localparam int DAYS_4Y   = DAYS_YEAR * 4 + 1;
	localparam int DAYS_100Y = DAYS_YEAR * 100 + 24;
	localparam int DAYS_400Y = DAYS_YEAR * 400 + 97;

	// Day index of 1 Mar 2000 counted from 1 Jan 1970.
	localparam int MARCH_2000_DAY = (946684800 / SECS_DAY) + 31 + 29;
	// Shift that moves a Unix day onto a count from 1 Mar 1600.
	localparam int UNIX_DAY_SHIFT = DAYS_400Y - MARCH_2000_DAY;

	localparam int BASE_YEAR    = 1600;
	localparam int YEARS_400    = 400;
	localparam int YEARS_100    = 100;
	localparam int WDAY_EPOCH   = 4;                    // 1 Jan 1970 was a Thursday
	localparam int JAN_FEB_DAYS = 31 + 28;
	localparam int MARCH_NUM    = 3;
	localparam int JAN_INDEX    = 10;                   // January in a March-based year

	localparam int MONTHS = 12;

	// First day of each month in a year that starts on 1 March.
	localparam logic [8:0] MONTH_START [MONTHS] = '{
		9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};

endpackage

// ===== hdl/stcd_split.sv =====
`timescale 1ns / 1ps

module stcd_split (
	input  logic               clk,
	input  stcd_pkg::stage_adv_t adv,
	input  logic [31:0]        ntp_seconds,
	output stcd_pkg::uday_t    udays,
	output stcd_pkg::daysec_t  remsecs
);
	import stcd_pkg::*;

	localparam int YW = 32 - DAY_SHIFT;
	localparam logic [22:0] DAY_RECIP = 23'((64'd1 << 32) / DAY_ODD);

	logic [31:0]          unix_s1;
	logic [15:0]          q0_s2;
	logic [YW-1:0]        y_s2;
	logic [DAY_SHIFT-1:0] lo_s2;
	uday_t                udays_s3;
	daysec_t              remsecs_s3;

	logic [47:0]   prod2;
	logic [YW-1:0] back3, diff3;
	logic [10:0]   rraw3, rfix3;
	logic [15:0]   qfix3;

	// Stage 1: drop the 1900-to-1970 offset, wrapping modulo 2^32.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			unix_s1 <= ntp_seconds - NTP_UNIX_OFFSET;
		end
	end

	// Stage 2: estimate the day count by reciprocal multiply.
	assign prod2 = 48'(unix_s1[31:DAY_SHIFT]) * 48'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			q0_s2 <= prod2[47:32];
			y_s2  <= unix_s1[31:DAY_SHIFT];
			lo_s2 <= unix_s1[DAY_SHIFT-1:0];
		end
	end

	// Stage 3: fix the estimate, which is at most one low.
	always_comb begin
		back3 = YW'(q0_s2) * YW'(DAY_ODD);
		diff3 = y_s2 - back3;
		rraw3 = diff3[10:0];
		if (rraw3 >= 11'(DAY_ODD)) begin
			qfix3 = q0_s2 + 16'd1;
			rfix3 = rraw3 - 11'(DAY_ODD);
		end else begin
			qfix3 = q0_s2;
			rfix3 = rraw3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			udays_s3   <= qfix3;
			remsecs_s3 <= {rfix3[9:0], lo_s2};
		end
	end

	assign udays   = udays_s3;
	assign remsecs = remsecs_s3;

endmodule

// ===== hdl/stcd_clock.sv =====
`timescale 1ns / 1ps

module stcd_clock (
	input  logic                 clk,
	input  stcd_pkg::stage_adv_t adv,
	input  stcd_pkg::daysec_t    remsecs,
	output stcd_pkg::clock_t     hms
);
	import stcd_pkg::*;

	localparam logic [18:0] MIN_RECIP  = 19'((64'd1 << 24) / SECS_MIN);
	localparam logic [10:0] HOUR_RECIP = 11'((64'd1 << 16) / SECS_MIN);

	logic [10:0] mt0_s4;
	daysec_t     x_s4;
	logic [10:0] mt_s5, mt_s6;
	logic [5:0]  sec_s5, sec_s6;
	logic [4:0]  h0_s6;
	clock_t      hms_s7, hms_s8, hms_s9, hms_s10;

	logic [35:0] prod4;
	logic [16:0] back5, diff5;
	logic [6:0]  r5;
	logic [10:0] mt5;
	logic [5:0]  sec5;
	logic [21:0] prod6;
	logic [10:0] back7, diff7;
	logic [6:0]  r7;
	clock_t      hms7;

	// Stage 4: estimate whole minutes.
	assign prod4 = 36'(remsecs) * 36'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			mt0_s4 <= prod4[34:24];
			x_s4   <= remsecs;
		end
	end

	// Stage 5: fix minutes, split off seconds.
	always_comb begin
		back5 = 17'(mt0_s4) * 17'(SECS_MIN);
		diff5 = x_s4 - back5;
		r5    = diff5[6:0];
		if (r5 >= 7'(SECS_MIN)) begin
			mt5  = mt0_s4 + 11'd1;
			sec5 = 6'(r5 - 7'(SECS_MIN));
		end else begin
			mt5  = mt0_s4;
			sec5 = r5[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			mt_s5  <= mt5;
			sec_s5 <= sec5;
		end
	end

	// Stage 6: estimate hours.
	assign prod6 = 22'(mt_s5) * 22'(HOUR_RECIP);

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			h0_s6  <= prod6[20:16];
			mt_s6  <= mt_s5;
			sec_s6 <= sec_s5;
		end
	end

	// Stage 7: fix hours, split off minutes.
	always_comb begin
		back7       = 11'(h0_s6) * 11'(SECS_MIN);
		diff7       = mt_s6 - back7;
		r7          = diff7[6:0];
		hms7.second = sec_s6;
		if (r7 >= 7'(SECS_MIN)) begin
			hms7.hour   = h0_s6 + 5'd1;
			hms7.minute = 6'(r7 - 7'(SECS_MIN));
		end else begin
			hms7.hour   = h0_s6;
			hms7.minute = r7[5:0];
		end
	end

	// Stages 7 to 10: hold time of day in step with the date path.
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			hms_s7 <= hms7;
		end
		if (adv[8]) begin
			hms_s8 <= hms_s7;
		end
		if (adv[9]) begin
			hms_s9 <= hms_s8;
		end
		if (adv[10]) begin
			hms_s10 <= hms_s9;
		end
	end

	assign hms = hms_s10;

endmodule

// ===== hdl/stcd_calendar.sv =====
`timescale 1ns / 1ps

module stcd_calendar (
	input  logic                 clk,
	input  stcd_pkg::stage_adv_t adv,
	input  stcd_pkg::uday_t      udays,
	output stcd_pkg::date_t      date
);
	import stcd_pkg::*;

	localparam logic [13:0] QUAD_RECIP  = 14'((64'd1 << 24) / DAYS_4Y);
	localparam int          WDAY_CHUNKS = 6;

	logic [17:0] rem_s4;
	logic        qc_s4;
	logic [5:0]  wsum_s4;
	logic [15:0] rem2_s5, rem2_s6;
	logic [11:0] yr_s5, yr_s6, yr_s7, yr_s8, yr_s9;
	logic        c0_s5, c0_s6, c0_s7;
	logic [2:0]  wday_s5, wday_s6, wday_s7, wday_s8, wday_s9;
	logic [4:0]  q0_s6;
	logic        last_s6;
	logic [10:0] rem3_s7;
	logic        qnz_s7;
	logic [8:0]  rem4_s8, rem4_s9;
	logic        leap_s8;
	logic [3:0]  m_s9;
	logic [8:0]  yday_s9;
	date_t       date_s10;

	logic [15:0] w4;
	logic [17:0] wide4;
	logic [5:0]  wsum4;
	logic [1:0]  c5;
	logic [3:0]  t5;
	logic [2:0]  u5;
	logic [29:0] prod6;
	logic [15:0] diff7;
	logic [11:0] r7;
	logic [4:0]  q7;
	logic [10:0] rem3;
	logic [1:0]  ry8;
	logic [10:0] diff8;
	logic [3:0]  m9;
	logic [9:0]  ys9, ylim9;
	logic [8:0]  dd10;

	// Stage 4: pick the 400-year cycle, rebase onto 1 Mar 1600 or 1 Mar 2000, start the weekday fold.
	always_comb begin
		w4    = udays + 16'(WDAY_EPOCH);
		wide4 = {2'b00, w4};
		wsum4 = '0;
		for (int i = 0; i < WDAY_CHUNKS; i++) begin
			wsum4 = wsum4 + 6'(wide4[3*i +: 3]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			qc_s4   <= (udays >= 16'(MARCH_2000_DAY));
			rem_s4  <= (udays >= 16'(MARCH_2000_DAY)) ?
				18'(udays) - 18'(MARCH_2000_DAY) : 18'(udays) + 18'(UNIX_DAY_SHIFT);
			wsum_s4 <= wsum4;
		end
	end

	// Stage 5: century within the cycle; finish the weekday fold (8 = 1 mod 7).
	always_comb begin
		c5 = 2'(rem_s4 >= 18'(DAYS_100Y)) + 2'(rem_s4 >= 18'(2 * DAYS_100Y))
			+ 2'(rem_s4 >= 18'(3 * DAYS_100Y));
		t5 = 4'(wsum_s4[5:3]) + 4'(wsum_s4[2:0]);
		u5 = 3'(t5[3]) + t5[2:0];
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			rem2_s5 <= 16'(rem_s4 - 18'(c5) * 18'(DAYS_100Y));
			yr_s5   <= 12'(BASE_YEAR) + (qc_s4 ? 12'(YEARS_400) : 12'd0)
				+ 12'(c5) * 12'(YEARS_100);
			c0_s5   <= (c5 == 2'd0);
			wday_s5 <= (u5 == 3'd7) ? 3'd0 : u5;
		end
	end

	// Stage 6: estimate the 4-year cycle; flag the extra day of a leap century.
	assign prod6 = 30'(rem2_s5) * 30'(QUAD_RECIP);

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			q0_s6   <= prod6[28:24];
			last_s6 <= (rem2_s5 == 16'(DAYS_100Y));
			rem2_s6 <= rem2_s5;
			yr_s6   <= yr_s5;
			c0_s6   <= c0_s5;
			wday_s6 <= wday_s5;
		end
	end

	// Stage 7: fix the 4-year count; clamp the leap day into the last cycle.
	always_comb begin
		diff7 = rem2_s6 - 16'(q0_s6) * 16'(DAYS_4Y);
		r7    = diff7[11:0];
		if (last_s6) begin
			q7   = 5'(DAYS_100Y / DAYS_4Y);
			rem3 = 11'(DAYS_100Y - (DAYS_100Y / DAYS_4Y) * DAYS_4Y);
		end else if (r7 >= 12'(DAYS_4Y)) begin
			q7   = q0_s6 + 5'd1;
			rem3 = 11'(r7 - 12'(DAYS_4Y));
		end else begin
			q7   = q0_s6;
			rem3 = r7[10:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			rem3_s7 <= rem3;
			qnz_s7  <= (q7 != 5'd0);
			yr_s7   <= yr_s6 + (12'(q7) << 2);
			c0_s7   <= c0_s6;
			wday_s7 <= wday_s6;
		end
	end

	// Stage 8: single year within the 4-year cycle, clamped at three.
	always_comb begin
		ry8 = 2'(rem3_s7 >= 11'(DAYS_YEAR)) + 2'(rem3_s7 >= 11'(2 * DAYS_YEAR))
			+ 2'(rem3_s7 >= 11'(3 * DAYS_YEAR));
		diff8 = rem3_s7 - 11'(ry8) * 11'(DAYS_YEAR);
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			rem4_s8 <= diff8[8:0];
			leap_s8 <= (ry8 == 2'd0) && (qnz_s7 || c0_s7);
			yr_s8   <= yr_s7 + 12'(ry8);
			wday_s8 <= wday_s7;
		end
	end

	// Stage 9: month index and day of the January-based year.
	always_comb begin
		m9 = '0;
		for (int k = 1; k < MONTHS; k++) begin
			m9 = m9 + 4'(rem4_s8 >= MONTH_START[k]);
		end
		ys9   = 10'(rem4_s8) + 10'(JAN_FEB_DAYS) + 10'(leap_s8);
		ylim9 = 10'(DAYS_YEAR) + 10'(leap_s8);
		if (ys9 >= ylim9) begin
			ys9 = ys9 - ylim9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			m_s9    <= m9;
			yday_s9 <= ys9[8:0];
			rem4_s9 <= rem4_s8;
			yr_s9   <= yr_s8;
			wday_s9 <= wday_s8;
		end
	end

	// Stage 10: day of month; wrap January and February into the next year.
	assign dd10 = rem4_s9 - MONTH_START[m_s9] + 9'd1;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			date_s10.day_of_month <= dd10[4:0];
			date_s10.month        <= (m_s9 < 4'(JAN_INDEX)) ?
				m_s9 + 4'(MARCH_NUM) : m_s9 - 4'(JAN_INDEX - 1);
			date_s10.year         <= yr_s9 + 12'(m_s9 >= 4'(JAN_INDEX));
			date_s10.week_day     <= wday_s9;
			date_s10.year_day     <= yday_s9;
		end
	end

	assign date = date_s10;

endmodule

// ===== hdl/seconds_to_calendar_date_core.sv =====
`timescale 1ns / 1ps
`include "seconds_to_calendar_date_core_macros.svh"

// Converts a 32-bit NTP seconds count (era 0, seconds since 1 Jan 1900 UTC) into the
// Gregorian date and UTC time of day. Counts below the 1970 offset wrap and land in
// 2036..2106. The block is a ten-stage pipeline: it takes one request per clock whenever
// req_stall is low, without waiting for earlier results to come out.
// The depth is set by the chain of constant-reciprocal multipliers (days, minutes,
// hours, 4-year cycles), each followed by its own correction stage. A stall on the
// result side first fills empty stages, so req_stall rises only once all ten stages
// hold work. There is no configuration and no state beyond the pipeline itself.
module seconds_to_calendar_date_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        req_valid,
	output logic        req_stall,
	input  logic [31:0] ntp_seconds,

	output logic        res_valid,
	input  logic        res_stall,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month,
	output logic [11:0] year,
	output logic [2:0]  week_day,
	output logic [8:0]  year_day
);
	import stcd_pkg::*;

	localparam logic [3:0] MONTH_JAN = 4'd1;

	// One valid bit per stage; a stage loads when it is empty or its content moves on.
	logic [NUM_STAGES:1] stage_valid_q;
	stage_adv_t          adv;

	uday_t   udays;
	daysec_t remsecs;
	clock_t  hms;
	date_t   date;

	// Advance from the output backward so bubbles collapse under a stall.
	always_comb begin
		adv[NUM_STAGES] = !stage_valid_q[NUM_STAGES] || !res_stall;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			adv[k] = !stage_valid_q[k] || adv[k + 1];
		end
	end

	assign req_stall = !adv[1];
	assign res_valid = stage_valid_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (adv[1]) begin
				stage_valid_q[1] <= req_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) begin
					stage_valid_q[k] <= stage_valid_q[k - 1];
				end
			end
		end
	end

	// Stages 1 to 3: Unix seconds, then whole days and seconds within the day.
	stcd_split u_split (
		.clk         (clk),
		.adv         (adv),
		.ntp_seconds (ntp_seconds),
		.udays       (udays),
		.remsecs     (remsecs)
	);

	// Stages 4 to 10: hour, minute and second, held in step with the date path.
	stcd_clock u_clock (
		.clk     (clk),
		.adv     (adv),
		.remsecs (remsecs),
		.hms     (hms)
	);

	// Stages 4 to 10: cycle split, month search, weekday and day of year.
	stcd_calendar u_calendar (
		.clk   (clk),
		.adv   (adv),
		.udays (udays),
		.date  (date)
	);

	assign second       = hms.second;
	assign minute       = hms.minute;
	assign hour         = hms.hour;
	assign day_of_month = date.day_of_month;
	assign month        = date.month;
	assign year         = date.year;
	assign week_day     = date.week_day;
	assign year_day     = date.year_day;

	// An accepted request must occupy the first stage on the next cycle.
	`STCD_ASSERT_NEXT(a_req_lands, clk, arst_n, req_valid && !req_stall, stage_valid_q[1], "accepted request lost at stage 1")

	// Back-pressure reaches the request side only with every stage full.
	`STCD_ASSERT_IMPL(a_stall_full, clk, arst_n, req_stall, (&stage_valid_q) && res_stall, "request stalled with a free stage")

	// Time of day stays in range.
	`STCD_ASSERT_IMPL(a_hms_range, clk, arst_n, res_valid, (second < 6'(SECS_MIN)) && (minute < 6'(SECS_MIN)) && (hour < 5'd24), "time of day out of range")

	// Date fields stay in range.
	`STCD_ASSERT_IMPL(a_date_range, clk, arst_n, res_valid, (week_day < 3'd7) && (month >= MONTH_JAN) && (month <= 4'(MONTHS)) && (day_of_month != 5'd0), "date out of range")

	// In January the day of year follows the day of month.
	`STCD_ASSERT_IMPL(a_jan_yday, clk, arst_n, res_valid && (month == MONTH_JAN), year_day == 9'(day_of_month) - 9'd1, "January day of year mismatch")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Checks the NTP-seconds to calendar-date pipeline. A short table of
// directed requests covers the ends of the 32-bit range, the wrap below the
// 1970 offset, leap days, and the borders of the 400-, 100- and 4-year
// cycles. A few rows carry a date that was worked out by hand. The rest of
// the rows, and the random requests after them, are checked against a date
// predictor that this file holds. The random part runs in four phases:
// no idling, an idle sender, a stalling receiver, and both at once.
module tb;
	import stcd_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_PER_PHASE = 200;
	// March-based month lengths, entry 0 is March. Entry 11 is February.
	localparam logic [11:0][4:0] MARCH_LEN = {
		5'd29, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	// Seconds from 1 Jan 1970 to 1 Mar 2000.
	localparam longint MARCH_2000_SECS = 64'sd951868800;

	typedef struct packed {
		clock_t tod;
		date_t  cal;
	} stamp_t;

	typedef struct {
		logic [31:0] ntp;
		bit          fixed;
		stamp_t      want;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [31:0] ntp_seconds = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [4:0]  day_of_month;
	logic [3:0]  month;
	logic [11:0] year;
	logic [2:0]  week_day;
	logic [8:0]  year_day;

	stamp_t        pending_dates[$];
	directed_row_t date_table[$];
	int            errors = 0;
	int            cycles = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;

	seconds_to_calendar_date_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.ntp_seconds  (ntp_seconds),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.second       (second),
		.minute       (minute),
		.hour         (hour),
		.day_of_month (day_of_month),
		.month        (month),
		.year         (year),
		.week_day     (week_day),
		.year_day     (year_day)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Remainder that is never negative, so the quotient rounds toward minus infinity.
	function automatic longint floor_mod(input longint a, input longint b);
		longint r;
		r = a % b;
		if (r < 0) begin
			r += b;
		end
		return r;
	endfunction

	// Work out the civil date and time of day for one NTP seconds count.
	function automatic stamp_t civil_from_ntp(input logic [31:0] ntp);
		logic [31:0] unix_s;
		longint      secs, days, day_secs, wday, era, rem_days;
		longint      cent, quad, yr, leap, yday, years, mon;
		stamp_t      r;
		// Wrap modulo 2^32, then count from 1 Mar 2000 so that leap days sit last.
		unix_s = ntp - NTP_UNIX_OFFSET;
		secs = longint'({32'd0, unix_s}) - MARCH_2000_SECS;
		day_secs = floor_mod(secs, SECS_DAY);
		days = (secs - day_secs) / SECS_DAY;
		// 1 Mar 2000 was a Wednesday.
		wday = floor_mod(days + 3, 7);
		rem_days = floor_mod(days, DAYS_400Y);
		era = (days - rem_days) / DAYS_400Y;
		// Clamp each cycle count so that the extra leap day falls in the last year.
		cent = rem_days / DAYS_100Y;
		if (cent == 4) begin
			cent = 3;
		end
		rem_days -= cent * DAYS_100Y;
		quad = rem_days / DAYS_4Y;
		if (quad == 25) begin
			quad = 24;
		end
		rem_days -= quad * DAYS_4Y;
		yr = rem_days / DAYS_YEAR;
		if (yr == 4) begin
			yr = 3;
		end
		rem_days -= yr * DAYS_YEAR;
		leap = (yr == 0 && (quad != 0 || cent == 0)) ? 1 : 0;
		yday = rem_days + 31 + 28 + leap;
		if (yday >= DAYS_YEAR + leap) begin
			yday -= DAYS_YEAR + leap;
		end
		years = yr + 4 * quad + 100 * cent + 400 * era;
		// Walk at most eleven months; whatever is left belongs to February.
		mon = 0;
		while (mon < 11 && longint'(MARCH_LEN[mon]) <= rem_days) begin
			rem_days -= longint'(MARCH_LEN[mon]);
			mon++;
		end
		mon += 2;
		if (mon >= 12) begin
			mon -= 12;
			years++;
		end
		r.tod.second = 6'(day_secs % 60);
		r.tod.minute = 6'((day_secs / 60) % 60);
		r.tod.hour = 5'(day_secs / 3600);
		r.cal.day_of_month = 5'(rem_days + 1);
		r.cal.month = 4'(mon + 1);
		r.cal.year = 12'(years + 2000);
		r.cal.week_day = 3'(wday);
		r.cal.year_day = 9'(yday);
		return r;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	// Add one row to the directed table. With fixed set, the date given here is the
	// expectation; otherwise the predictor supplies it.
	task automatic add_row(input logic [31:0] ntp, input bit fixed,
			input int s, input int mi, input int h, input int d, input int mo,
			input int y, input int wd, input int yd);
		directed_row_t row;
		row.ntp = ntp;
		row.fixed = fixed;
		row.want.tod.second = 6'(s);
		row.want.tod.minute = 6'(mi);
		row.want.tod.hour = 5'(h);
		row.want.cal.day_of_month = 5'(d);
		row.want.cal.month = 4'(mo);
		row.want.cal.year = 12'(y);
		row.want.cal.week_day = 3'(wd);
		row.want.cal.year_day = 9'(yd);
		date_table.push_back(row);
	endtask

	// Offer one request, idling first as the current phase asks. Hold the payload
	// until the block takes it, then queue what it should produce.
	task automatic send_request(input logic [31:0] ntp, input stamp_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			ntp_seconds <= $urandom;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		ntp_seconds <= ntp;
		do begin
			@(posedge clk);
		end while (req_stall);
		pending_dates.push_back(want);
	endtask

	// Take results as the receiver stall allows and compare each with the oldest
	// expectation. Values read here are the ones from before the edge.
	always @(posedge clk) begin
		stamp_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pending_dates.size() == 0) begin
					report_error("result with no request waiting for it");
				end else begin
					want = pending_dates.pop_front();
					if (second !== want.tod.second)
						report_error($sformatf("second %0d, want %0d",
							second, want.tod.second));
					if (minute !== want.tod.minute)
						report_error($sformatf("minute %0d, want %0d",
							minute, want.tod.minute));
					if (hour !== want.tod.hour)
						report_error($sformatf("hour %0d, want %0d", hour, want.tod.hour));
					if (day_of_month !== want.cal.day_of_month)
						report_error($sformatf("day_of_month %0d, want %0d",
							day_of_month, want.cal.day_of_month));
					if (month !== want.cal.month)
						report_error($sformatf("month %0d, want %0d",
							month, want.cal.month));
					if (year !== want.cal.year)
						report_error($sformatf("year %0d, want %0d", year, want.cal.year));
					if (week_day !== want.cal.week_day)
						report_error($sformatf("week_day %0d, want %0d",
							week_day, want.cal.week_day));
					if (year_day !== want.cal.year_day)
						report_error($sformatf("year_day %0d, want %0d",
							year_day, want.cal.year_day));
				end
			end
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Drop the run if it hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [31:0] ntp;
		logic [31:0] day_idx;
		logic [31:0] day_sec;
		stamp_t      want;

		// Hand-checked dates: the 1970 epoch, both ends of NTP era 0, the second
		// before the wrap, and the last second of the 2000 leap day.
		add_row(32'd2208988800, 1'b1, 0, 0, 0, 1, 1, 1970, 4, 0);
		add_row(32'd0, 1'b1, 16, 28, 6, 7, 2, 2036, 4, 37);
		add_row(32'hFFFF_FFFF, 1'b1, 15, 28, 6, 7, 2, 2036, 4, 37);
		add_row(32'd2208988799, 1'b1, 15, 28, 6, 7, 2, 2106, 0, 37);
		add_row(32'd3160857599, 1'b1, 59, 59, 23, 29, 2, 2000, 2, 59);
		// Predicted rows: cycle borders, leap days, a non-leap century, bit patterns.
		add_row(32'd3160857600, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);  // 1 Mar 2000
		add_row(32'd3155673599, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);  // end of 1999
		add_row(32'd3155673600, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);  // start of 2000
		add_row(32'd2277201600, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);  // 29 Feb 1972 noon
		add_row(32'd2240611199, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);  // end of 1 Jan 1971
		add_row(32'd2021563903, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);  // 28 Feb 2100, no leap
		add_row(32'd2021563904, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);  // 1 Mar 2100
		add_row(32'd2016466304, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);  // start of 2100
		add_row(32'd2147707904, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);  // 29 Feb 2104
		add_row(32'd61505152, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);    // signed 32-bit overflow
		add_row(32'hAAAA_AAAA, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(32'h5555_5555, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(32'h8000_0000, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(32'h7FFF_FFFF, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);

		// Hold reset, then release it on an edge.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table back to back.
		foreach (date_table[i]) begin
			want = date_table[i].fixed ? date_table[i].want : civil_from_ntp(date_table[i].ntp);
			send_request(date_table[i].ntp, want);
		end

		// Random phases: none idle, sender idle, receiver stalling, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				case ($urandom_range(3))
					0: ntp = $urandom;
					1, 2: begin
						// Mostly land on or next to midnight so month and year ends come up often.
						day_idx = $urandom_range(49709);
						case ($urandom_range(2))
							0: day_sec = 0;
							1: day_sec = SECS_DAY - 1;
							default: day_sec = $urandom_range(SECS_DAY - 1);
						endcase
						ntp = day_idx * SECS_DAY + day_sec + NTP_UNIX_OFFSET;
					end
					default: begin
						// Stay close to the era wrap or to the 1970 offset.
						if ($urandom_range(1))
							ntp = 32'($urandom_range(4095)) - 32'd2048;
						else
							ntp = NTP_UNIX_OFFSET + 32'($urandom_range(4095)) - 32'd2048;
					end
				endcase
				send_request(ntp, civil_from_ntp(ntp));
			end
		end
		req_valid <= 1'b0;

		// Drain, then give stray results time to show up.
		while (pending_dates.size() != 0) begin
			@(posedge clk);
		end
		repeat (4 * NUM_STAGES) @(posedge clk);

		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
